// File: hw/rtl/rcrb_pkg.sv
package rcrb_pkg;

  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_GET   = 3'd1;
  localparam logic [2:0] ACT_ROTL  = 3'd2;
  localparam logic [2:0] ACT_ROTR  = 3'd3;
  localparam logic [2:0] ACT_FILL  = 3'd4;
  localparam logic [2:0] ACT_COUNT = 3'd5;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] cell_index;
    logic [7:0] byte_value;
    logic [7:0] pattern_a;
    logic [8:0] run_a;
    logic [7:0] pattern_b;
    logic [8:0] run_b;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [8:0] match_count;
  } res_t;

endpackage

// File: hw/rtl/rcrb_ram.sv
module rcrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/rcrb_core.sv
module rcrb_core import rcrb_pkg::*; #(
  parameter int RING_DEPTH = 256,
  parameter int AW = $clog2(RING_DEPTH),
  parameter int LW = $clog2(RING_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [LW-1:0] length,
  input  logic          in_valid,
  output logic          in_ready,
  input  item_t         item,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output logic [7:0]    mem_wdata,
  input  logic [7:0]    mem_rdata
);

  localparam int SW = ((LW > 8) ? LW : 8) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_GETW  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_CNT   = 3'd4;
  localparam logic [2:0] ST_CNTT  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] i_r, i_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [9:0]    ph_r, ph_nxt;
  logic          cmpv_r, cmpv_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  res_t          res_r, res_nxt;
  logic [7:0]    val_r, pa_r, pb_r;
  logic [8:0]    ra_r;
  logic [9:0]    sum_r;

  logic [LW-1:0] len_m1, head_p1, p_p1;
  logic [AW-1:0] head_left, head_right, p_wrap;
  logic [SW-1:0] phys_sum, phys;
  logic          idx_ok, last, hit;
  logic [9:0]    ph_p1;
  logic [7:0]    fill_byte;
  logic [8:0]    cnt_sum;

  assign len_m1   = length - LW'(1);
  assign last     = (i_r == len_m1);
  assign idx_ok   = SW'(item.cell_index) < SW'(length);
  // head < length and index < length, so one subtract wraps the sum
  assign phys_sum = SW'(head_r) + SW'(item.cell_index);
  assign phys     = (phys_sum >= SW'(length)) ? phys_sum - SW'(length) : phys_sum;

  assign head_p1    = LW'(head_r) + LW'(1);
  assign head_left  = (head_p1 == length) ? '0 : head_p1[AW-1:0];
  assign head_right = (head_r == '0) ? len_m1[AW-1:0] : head_r - AW'(1);

  assign p_p1   = LW'(p_r) + LW'(1);
  assign p_wrap = (p_p1 == length) ? '0 : p_p1[AW-1:0];

  // phase runs 0 .. run_a+run_b-1 in place of i mod (run_a+run_b)
  assign ph_p1     = ph_r + 10'd1;
  assign fill_byte = (sum_r == '0) ? SPACE_BYTE :
                     (ph_r < {1'b0, ra_r}) ? pa_r : pb_r;

  assign hit     = cmpv_r && (mem_rdata == val_r);
  assign cnt_sum = cnt_r + {8'd0, hit};

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    head_nxt  = head_r;
    p_nxt     = p_r;
    ph_nxt    = ph_r;
    cmpv_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_addr  = i_r[AW-1:0];
    mem_wdata = SPACE_BYTE;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_addr  = phys[AW-1:0];
        mem_wdata = item.byte_value;
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = ST_FIN;
          unique case (item.action)
            ACT_SET: mem_we = idx_ok;
            ACT_GET: begin
              if (idx_ok) begin
                state_nxt = ST_GETW;
              end else begin
                res_nxt.read_data = SPACE_BYTE;
              end
            end
            ACT_ROTL: head_nxt = head_left;
            ACT_ROTR: head_nxt = head_right;
            ACT_FILL: begin
              state_nxt = ST_FILL;
              i_nxt     = '0;
              p_nxt     = head_r;
              ph_nxt    = '0;
            end
            ACT_COUNT: begin
              state_nxt = ST_CNT;
              i_nxt     = '0;
              cnt_nxt   = '0;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + LW'(1);
        end
      end
      ST_GETW: begin
        res_nxt.read_data = mem_rdata;
        state_nxt         = ST_FIN;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = p_r;
        mem_wdata = fill_byte;
        p_nxt     = p_wrap;
        ph_nxt    = (ph_p1 == sum_r) ? '0 : ph_p1;
        if (last) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt = i_r + LW'(1);
        end
      end
      ST_CNT: begin
        // read issued now, compared next cycle
        cmpv_nxt = 1'b1;
        cnt_nxt  = cnt_sum;
        if (last) begin
          state_nxt = ST_CNTT;
        end else begin
          i_nxt = i_r + LW'(1);
        end
      end
      ST_CNTT: begin
        res_nxt.match_count = cnt_sum;
        state_nxt           = ST_FIN;
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = ST_CLEAR;
      i_nxt     = '0;
      head_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      i_r     <= '0;
      head_r  <= '0;
      cmpv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      head_r  <= head_nxt;
      cmpv_r  <= cmpv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    ph_r  <= ph_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      val_r <= item.byte_value;
      pa_r  <= item.pattern_a;
      pb_r  <= item.pattern_b;
      ra_r  <= item.run_a;
      sum_r <= {1'b0, item.run_a} + {1'b0, item.run_b};
    end
  end

  assign res = res_r;

endmodule

// File: hw/rtl/rotating_char_ring_buffer.sv
// Byte ring with a movable head, one result beat per input beat. Set, rotate and undefined
// actions go from accept straight to the result register, get waits on the cell read, and
// fill and count walk one ring cell per cycle through the single port of the cell RAM. After
// reset and after every ring_length write the block sweeps the new length of cells to space,
// one per cycle (all 256 cells after reset by default), with in_ready low. A finished result
// waits in the output register while the next beat is accepted.
module rotating_char_ring_buffer import rcrb_pkg::*; #(
  parameter int RING_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [7:0] in_cell_index,
  input  logic [7:0] in_byte_value,
  input  logic [7:0] in_pattern_a,
  input  logic [8:0] in_run_a,
  input  logic [7:0] in_pattern_b,
  input  logic [8:0] in_run_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [8:0] out_match_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_ring_length
);

  localparam int AW      = $clog2(RING_DEPTH);
  localparam int LW      = $clog2(RING_DEPTH + 1);
  localparam int CW      = (LW > 9) ? LW : 9;
  localparam int RST_LEN = (RING_DEPTH < 256) ? RING_DEPTH : 256;

  logic [LW-1:0] len_r;
  logic [CW-1:0] cfg_ext, cfg_lim;
  logic          cfg_we;
  item_t         item;
  res_t          res;
  logic          res_valid, res_ready;
  logic          out_valid_r;
  res_t          out_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_ext   = CW'(cfg_ring_length);
  assign cfg_lim   = (cfg_ext == '0) ? CW'(1) :
                     (cfg_ext > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : cfg_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(RST_LEN);
    end else if (cfg_we) begin
      len_r <= cfg_lim[LW-1:0];
    end
  end

  assign item = '{action: in_action, cell_index: in_cell_index, byte_value: in_byte_value,
                  pattern_a: in_pattern_a, run_a: in_run_a, pattern_b: in_pattern_b,
                  run_b: in_run_b};

  rcrb_core #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW),
    .LW         (LW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .length    (len_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rcrb_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_r.read_data;
  assign out_match_count = out_r.match_count;

endmodule

// File: hw/rtl/rcrb_chk.sv
module rcrb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [8:0] out_match_count,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_match_count))
    else $error("result beat changed while stalled");

  // get and count never report together
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data == 8'd0) || (out_match_count == 9'd0))
    else $error("both result fields nonzero");

  // reset starts the clear sweep
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input ready right after length write");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

endmodule

bind rotating_char_ring_buffer rcrb_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_data   (out_read_data),
  .out_match_count (out_match_count),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready)
);

// File: sim/ring_shadow_check.sv
module ring_shadow_check import rcrb_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  item_t      in_beat,
  input  logic       out_valid,
  input  logic       out_ready,
  input  res_t       out_beat,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [8:0] cfg_ring_length,
  output int         errors,
  output int         outstanding,
  output int         checked
);

  logic [7:0] ring_img [DEPTH];
  int         head;
  int         ring_len;
  res_t       expected_results [$];

  task automatic report(string what, int got, int want);
    errors++;
    $display("ring check: %s got %0h expected %0h at result %0d", what, got, want, checked);
  endtask

  task automatic wipe_ring();
    foreach (ring_img[i]) ring_img[i] = SPACE_BYTE;
    head = 0;
  endtask

  function automatic res_t apply_action(item_t it);
    res_t r;
    int   span;
    r = '0;
    span = int'(it.run_a) + int'(it.run_b);
    case (it.action)
      ACT_SET: begin
        if (it.cell_index < ring_len) ring_img[(head + it.cell_index) % ring_len] = it.byte_value;
      end
      ACT_GET: begin
        r.read_data = (it.cell_index < ring_len) ?
                      ring_img[(head + it.cell_index) % ring_len] : SPACE_BYTE;
      end
      ACT_ROTL: head = (head + 1) % ring_len;
      ACT_ROTR: head = (head + ring_len - 1) % ring_len;
      ACT_FILL: begin
        for (int i = 0; i < ring_len; i++) begin
          if (span == 0) ring_img[(head + i) % ring_len] = SPACE_BYTE;
          else ring_img[(head + i) % ring_len] = ((i % span) < it.run_a) ? it.pattern_a :
                                                                           it.pattern_b;
        end
      end
      ACT_COUNT: begin
        for (int i = 0; i < ring_len; i++)
          if (ring_img[i] == it.byte_value) r.match_count++;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      ring_len = DEPTH;
      wipe_ring();
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ring_len = (cfg_ring_length == 0) ? 1 :
                   (cfg_ring_length > DEPTH) ? DEPTH : int'(cfg_ring_length);
        wipe_ring();
      end
      // result first: a beat taken at this edge cannot have its result out yet
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("result beat with nothing pending", int'(out_beat), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_beat.read_data !== want.read_data)
            report("read_data", int'(out_beat.read_data), int'(want.read_data));
          if (out_beat.match_count !== want.match_count)
            report("match_count", int'(out_beat.match_count), int'(want.match_count));
          checked++;
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_action(in_beat));
      outstanding <= expected_results.size();
    end
  end

endmodule

// File: sim/rotating_char_ring_buffer_tb.sv
module rotating_char_ring_buffer_tb;
  import rcrb_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int BEATS_PER_PHASE = 42;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  item_t      beat = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic [8:0] out_match_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_ring_length = '0;

  res_t       res_seen;
  int         errors;
  int         outstanding;
  int         checked;
  int         cycles = 0;
  int         burst_left = 0;
  bit         no_gaps = 0;
  int         len_now = 256;
  int         beats_sent = 0;
  int         fills_sent = 0;
  int         counts_sent = 0;
  int         lengths_used = 1;
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_left = 0;

  logic [8:0] fixed_len [9] = '{9'd2, 9'd511, 9'd5, 9'd1, 9'd33, 9'd256, 9'd0, 9'd8, 9'd129};

  assign res_seen = {out_read_data, out_match_count};

  rotating_char_ring_buffer #(.RING_DEPTH(256)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (beat.action),
    .in_cell_index  (beat.cell_index),
    .in_byte_value  (beat.byte_value),
    .in_pattern_a   (beat.pattern_a),
    .in_run_a       (beat.run_a),
    .in_pattern_b   (beat.pattern_b),
    .in_run_b       (beat.run_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_match_count(out_match_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_ring_length(cfg_ring_length)
  );

  ring_shadow_check #(.DEPTH(256)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_beat        (beat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_beat       (res_seen),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_ring_length(cfg_ring_length),
    .errors         (errors),
    .outstanding    (outstanding),
    .checked        (checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout with %0d results still pending", outstanding);
      $display("[rotating_char_ring_buffer] ERROR");
      $finish;
    end
  end

  // receiver: switches between always ready, coin flip and a fixed duty stall
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (cycles % 16) < 11;
      default:     out_ready <= 1'b1;
    endcase
  end

  function automatic item_t mk(logic [2:0] act, logic [7:0] idx, logic [7:0] val,
                               logic [7:0] pa, logic [8:0] ra, logic [7:0] pb,
                               logic [8:0] rb);
    item_t it;
    it.action = act;
    it.cell_index = idx;
    it.byte_value = val;
    it.pattern_a = pa;
    it.run_a = ra;
    it.pattern_b = pb;
    it.run_b = rb;
    return it;
  endfunction

  // bias toward a few bytes so counts find matches
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) return SPACE_BYTE;
    return 8'h41 + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [8:0] pick_run(int len);
    if ($urandom_range(0, 3) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, (len < 8) ? len : 8));
  endfunction

  function automatic item_t random_beat(int len);
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    it.action = (r < 28) ? ACT_SET : (r < 52) ? ACT_GET : (r < 60) ? ACT_ROTL :
                (r < 68) ? ACT_ROTR : (r < 80) ? ACT_FILL : (r < 95) ? ACT_COUNT :
                ($urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7);
    it.cell_index = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, len - 1)) :
                                                  8'($urandom_range(0, 255));
    it.byte_value = pick_byte();
    it.pattern_a = pick_byte();
    it.run_a = pick_run(len);
    it.pattern_b = pick_byte();
    it.run_b = pick_run(len);
    return it;
  endfunction

  task automatic send_beat(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    beat <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    beats_sent++;
    if (it.action == ACT_FILL) fills_sent++;
    if (it.action == ACT_COUNT) counts_sent++;
  endtask

  // only while idle: drain every pending result, then write the length
  task automatic write_length(logic [8:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_ring_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    len_now = (v == 0) ? 1 : (v > 256) ? 256 : int'(v);
    burst_left = 0;
    lengths_used++;
  endtask

  initial begin
    logic [8:0] next_len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // full ring at reset length
    send_beat(mk(ACT_GET,   8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_COUNT, 8'd0,   SPACE_BYTE, 8'h00, 9'd0, 8'h00, 9'd0));
    send_beat(mk(ACT_SET,   8'd0,   8'hFF, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_SET,   8'd255, 8'h00, 8'hFF, 9'd511, 8'hFF, 9'd511));
    send_beat(mk(ACT_GET,   8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_GET,   8'd255, 8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_ROTL,  8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_GET,   8'd255, 8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_ROTR,  8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_ROTR,  8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_GET,   8'd1,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_FILL,  8'd0,   8'h00, 8'hAA, 9'd3,   8'h55, 9'd2));
    send_beat(mk(ACT_COUNT, 8'd0,   8'hAA, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_GET,   8'd4,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    // both runs zero gives spaces; one zero run gives the other pattern
    send_beat(mk(ACT_FILL,  8'd0,   8'h00, 8'hAA, 9'd0,   8'h55, 9'd0));
    send_beat(mk(ACT_COUNT, 8'd0,   SPACE_BYTE, 8'h00, 9'd0, 8'h00, 9'd0));
    send_beat(mk(ACT_FILL,  8'd0,   8'h00, 8'h00, 9'd256, 8'hFF, 9'd0));
    send_beat(mk(ACT_FILL,  8'd0,   8'h00, 8'h11, 9'd0,   8'hEE, 9'd256));
    send_beat(mk(ACT_COUNT, 8'd0,   8'hEE, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_FILL,  8'd0,   8'h00, 8'hFF, 9'd511, 8'h00, 9'd511));
    send_beat(mk(ACT_COUNT, 8'd0,   8'hFF, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_RSVD6, 8'hFF,  8'hFF, 8'hFF, 9'd511, 8'hFF, 9'd511));
    send_beat(mk(ACT_RSVD7, 8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));

    // zero length is taken as a single cell
    write_length(9'd0);
    send_beat(mk(ACT_SET,   8'd1,   8'h41, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_ROTL,  8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_GET,   8'd0,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));
    send_beat(mk(ACT_GET,   8'd1,   8'h00, 8'h00, 9'd0,   8'h00, 9'd0));

    for (int p = 0; p < 12; p++) begin
      next_len = (p < 9) ? fixed_len[p] : 9'($urandom_range(1, 200));
      write_length(next_len);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BEATS_PER_PHASE; n++) send_beat(random_beat(len_now));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);

    $display("sent %0d beats (%0d fills, %0d counts) over %0d length settings", beats_sent,
             fills_sent, counts_sent, lengths_used);
    $display("%0d result beats compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("[rotating_char_ring_buffer] OK");
    end else begin
      $display("[rotating_char_ring_buffer] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rcrb_pkg.sv
hw/rtl/rcrb_ram.sv
hw/rtl/rcrb_core.sv
hw/rtl/rotating_char_ring_buffer.sv
hw/rtl/rcrb_chk.sv
sim/ring_shadow_check.sv
sim/rotating_char_ring_buffer_tb.sv
